/* design/alsd_pkg.sv */
// alsd_pkg: types, widths and constants shared by the axial link stiffness block
// no dependencies; compiled before every other file of the block
`default_nettype none

package alsd_pkg;

  // field and fixed-point widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned AXIS_FRAC  = 30;
  localparam int unsigned DIR_BITS   = 30;
  localparam int unsigned SNAP_SHIFT = 40;
  localparam int unsigned NLANE      = 6;

  // derived widths
  localparam int unsigned PROD_W  = 2 * DIR_BITS;      // r_i * r_j
  localparam int unsigned LAT_W   = PROD_W + 1;        // rx^2 + ry^2
  localparam int unsigned S_W     = PROD_W + 2;        // r . r
  localparam int unsigned SNUM_W  = 18;
  localparam int unsigned RHS_W   = S_W + SNUM_W;
  localparam int unsigned CMP_W   = LAT_W + SNAP_SHIFT;
  localparam int unsigned Q_W     = AXIS_FRAC + 2;     // integer bit, fraction, round bit
  localparam int unsigned P_W     = AXIS_FRAC + 1;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned KP_W    = DATA_W + P_W;
  localparam int unsigned FP_W    = 2 * DATA_W;
  localparam int unsigned ACC_W   = FP_W + 4;

  localparam logic [SNUM_W-1:0] SNAP_NUM = SNUM_W'(219902);
  localparam logic [P_W-1:0]    AXIS_ONE = P_W'(1) << AXIS_FRAC;
  localparam logic [DATA_W-1:0] K_RESET  = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] POS_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MAX  = {1'b1, {(DATA_W-1){1'b0}}};

  // lanes of the symmetric block
  localparam int unsigned L_XX = 0;
  localparam int unsigned L_YY = 1;
  localparam int unsigned L_ZZ = 2;
  localparam int unsigned L_XY = 3;
  localparam int unsigned L_XZ = 4;
  localparam int unsigned L_YZ = 5;

  // lane that holds block entry (row, col)
  localparam int unsigned LANE_OF [3][3] = '{
    '{L_XX, L_XY, L_XZ},
    '{L_XY, L_YY, L_YZ},
    '{L_XZ, L_YZ, L_ZZ}
  };

  typedef enum logic [1:0] {
    AXIS_GENERAL    = 2'd0,
    AXIS_SNAP_Z     = 2'd1,
    AXIS_COINCIDENT = 2'd2
  } axis_case_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] node_a_x;
    logic signed [DATA_W-1:0] node_a_y;
    logic signed [DATA_W-1:0] node_a_z;
    logic signed [DATA_W-1:0] node_b_x;
    logic signed [DATA_W-1:0] node_b_y;
    logic signed [DATA_W-1:0] node_b_z;
    logic signed [DATA_W-1:0] disp_a_x;
    logic signed [DATA_W-1:0] disp_a_y;
    logic signed [DATA_W-1:0] disp_a_z;
    logic signed [DATA_W-1:0] disp_b_x;
    logic signed [DATA_W-1:0] disp_b_y;
    logic signed [DATA_W-1:0] disp_b_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] k_xx;
    logic signed [DATA_W-1:0] k_yy;
    logic signed [DATA_W-1:0] k_zz;
    logic signed [DATA_W-1:0] k_xy;
    logic signed [DATA_W-1:0] k_xz;
    logic signed [DATA_W-1:0] k_yz;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic [1:0]               axis_case;
    logic                     saturated;
  } out_item_t;

  // what travels beside the axis math
  typedef struct packed {
    logic [2:0]             dn;     // sign of b - a per axis
    logic [2:0]             un;     // sign of ua - ub per axis
    logic [2:0][DATA_W-1:0] um;     // magnitude of ua - ub
    axis_case_t             acase;
  } meta_t;

  // front end to divider
  typedef struct packed {
    logic                       vld;
    meta_t                      meta;
    logic [S_W-1:0]             s;
    logic [NLANE-1:0][S_W-1:0]  n;
  } front_t;

  // divider to back end
  typedef struct packed {
    logic                       vld;
    meta_t                      meta;
    logic [NLANE-1:0][Q_W-1:0]  q;
  } quo_t;

  // p - q of two signed fields as {sign, magnitude}
  function automatic logic [DATA_W:0] sdiff(logic [DATA_W-1:0] p, logic [DATA_W-1:0] q);
    logic [DATA_W:0] d;
    logic [DATA_W:0] m;
    d = {p[DATA_W-1], p} - {q[DATA_W-1], q};
    m = d[DATA_W] ? (~d + 1'b1) : d;
    return {d[DATA_W], m[DATA_W-1:0]};
  endfunction

endpackage

`default_nettype wire

/* design/alsd_if.sv */
// alsd_if: valid/ready channel interfaces for input items, result items and config
// depends on alsd_pkg for the payload types
`default_nettype none

interface alsd_in_if;
  import alsd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface alsd_out_if;
  import alsd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface alsd_cfg_if;
  import alsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/axial_link_stiffness_3d_top.sv */
// axial link stiffness, 3d: each accepted input item passes through a pipeline of
// 6 front stages, 32 divider stages, one quotient bit each, and 5 back-end stages
// throughput one item per cycle; a stalled output freezes the whole pipeline
// synchronous active-low reset clears all valid bits and sets stiffness K to 1.0
// depends on alsd_pkg, alsd_if, alsd_front, alsd_div, alsd_back
`default_nettype none

module axial_link_stiffness_3d_top
  import alsd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  alsd_in_if.sink          in_if,
  alsd_out_if.source       out_if,
  alsd_cfg_if.sink         cfg_if
);

  logic [DATA_W-1:0] k_r;
  logic              en;
  logic              out_vld;
  out_item_t         out_data;
  front_t            front_q;
  quo_t              div_q;

  // stiffness register; write it only while the pipeline is idle (the block does not enforce this)
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= K_RESET;
    else if (cfg_if.valid && cfg_if.ready) k_r <= cfg_if.data;
  end

  // whole pipeline advances unless a result item is waiting
  assign en           = !out_vld || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = out_vld;
  assign out_if.data  = out_data;

  alsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_if.valid),
    .in_item (in_if.data),
    .fo      (front_q)
  );

  alsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .fi    (front_q),
    .qo    (div_q)
  );

  alsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .qi       (div_q),
    .stiff    (k_r),
    .out_vld  (out_vld),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* design/alsd_front.sv */
// alsd_front: six-stage front end: differences, normalize, products, sums, axis case
// depends on alsd_pkg
`default_nettype none

module alsd_front
  import alsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  in_item_t in_item,
  output front_t   fo
);

  // stage 1: exact differences as sign and magnitude
  logic [2:0][DATA_W:0] dd;
  logic [2:0][DATA_W:0] ud;
  logic                 v1_r;
  logic [2:0][DATA_W-1:0] dm1_r;
  meta_t                meta1_r;

  always_comb begin
    dd[0] = sdiff(in_item.node_b_x, in_item.node_a_x);
    dd[1] = sdiff(in_item.node_b_y, in_item.node_a_y);
    dd[2] = sdiff(in_item.node_b_z, in_item.node_a_z);
    ud[0] = sdiff(in_item.disp_a_x, in_item.disp_b_x);
    ud[1] = sdiff(in_item.disp_a_y, in_item.disp_b_y);
    ud[2] = sdiff(in_item.disp_a_z, in_item.disp_b_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dm1_r[i]      <= dd[i][DATA_W-1:0];
        meta1_r.dn[i] <= dd[i][DATA_W];
        meta1_r.um[i] <= ud[i][DATA_W-1:0];
        meta1_r.un[i] <= ud[i][DATA_W];
      end
      meta1_r.acase <= AXIS_GENERAL;
    end
  end

  // stage 2: common right shift so all magnitudes fit the direction width
  logic [DATA_W-1:0]        orv;
  logic [2:0][DIR_BITS-1:0] rr;
  logic                     v2_r;
  logic [2:0][DIR_BITS-1:0] r2_r;
  logic                     z2_r;
  meta_t                    meta2_r;

  always_comb begin
    orv = dm1_r[0] | dm1_r[1] | dm1_r[2];
    for (int i = 0; i < 3; i++) begin
      if (orv[DATA_W-1]) rr[i] = dm1_r[i][DATA_W-1:2];
      else if (orv[DATA_W-2]) rr[i] = dm1_r[i][DATA_W-2:1];
      else rr[i] = dm1_r[i][DIR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r    <= rr;
      z2_r    <= (orv == '0);
      meta2_r <= meta1_r;
    end
  end

  // stage 3: six products of the shifted axis
  logic                      v3_r;
  logic [NLANE-1:0][PROD_W-1:0] p3_r;
  logic                      z3_r;
  meta_t                     meta3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r[L_XX] <= r2_r[0] * r2_r[0];
      p3_r[L_YY] <= r2_r[1] * r2_r[1];
      p3_r[L_ZZ] <= r2_r[2] * r2_r[2];
      p3_r[L_XY] <= r2_r[0] * r2_r[1];
      p3_r[L_XZ] <= r2_r[0] * r2_r[2];
      p3_r[L_YZ] <= r2_r[1] * r2_r[2];
      z3_r       <= z2_r;
      meta3_r    <= meta2_r;
    end
  end

  // stage 4: lateral and total squared length
  logic [LAT_W-1:0] lat_nxt;
  logic             v4_r;
  logic [LAT_W-1:0] lat4_r;
  logic [S_W-1:0]   s4_r;
  logic [NLANE-1:0][PROD_W-1:0] p4_r;
  logic             z4_r;
  meta_t            meta4_r;

  assign lat_nxt = LAT_W'(p3_r[L_XX]) + LAT_W'(p3_r[L_YY]);

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat4_r  <= lat_nxt;
      s4_r    <= S_W'(lat_nxt) + S_W'(p3_r[L_ZZ]);
      p4_r    <= p3_r;
      z4_r    <= z3_r;
      meta4_r <= meta3_r;
    end
  end

  // stage 5: snap threshold product
  logic             v5_r;
  logic [LAT_W-1:0] lat5_r;
  logic [S_W-1:0]   s5_r;
  logic [RHS_W-1:0] rhs5_r;
  logic [NLANE-1:0][PROD_W-1:0] p5_r;
  logic             z5_r;
  meta_t            meta5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat5_r  <= lat4_r;
      s5_r    <= s4_r;
      rhs5_r  <= s4_r * SNAP_NUM;
      p5_r    <= p4_r;
      z5_r    <= z4_r;
      meta5_r <= meta4_r;
    end
  end

  // stage 6: axis case decision, hand off to the divider
  logic       snap;
  axis_case_t acase_nxt;
  meta_t      meta6_nxt;
  logic       v6_r;
  front_t     fo_r;

  always_comb begin
    snap = {lat5_r, {SNAP_SHIFT{1'b0}}} < CMP_W'(rhs5_r);
    if (z5_r) acase_nxt = AXIS_COINCIDENT;
    else if (snap) acase_nxt = AXIS_SNAP_Z;
    else acase_nxt = AXIS_GENERAL;
    meta6_nxt       = meta5_r;
    meta6_nxt.acase = acase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_r.vld  <= 1'b0;
      fo_r.meta <= meta6_nxt;
      fo_r.s    <= s5_r;
      for (int l = 0; l < NLANE; l++) fo_r.n[l] <= S_W'(p5_r[l]);
    end
  end

  always_comb begin
    fo     = fo_r;
    fo.vld = v6_r;
  end

endmodule

`default_nettype wire

/* design/alsd_div.sv */
// alsd_div: six-lane restoring divider, one quotient bit per pipeline stage
// depends on alsd_pkg; fed by alsd_front
`default_nettype none

module alsd_div
  import alsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  front_t fi,
  output quo_t   qo
);

  logic                      vld_r  [DIV_STEPS];
  meta_t                     meta_r [DIV_STEPS];
  logic [S_W-1:0]            s_r    [DIV_STEPS];
  logic [NLANE-1:0][S_W-1:0] rem_r  [DIV_STEPS];
  logic [NLANE-1:0][Q_W-1:0] quo_r  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                      cur_vld;
    meta_t                     cur_meta;
    logic [S_W-1:0]            cur_s;
    logic [NLANE-1:0][S_W-1:0] cur_rem;
    logic [NLANE-1:0][Q_W-1:0] cur_quo;
    logic [NLANE-1:0][S_W:0]   trial;
    logic [NLANE-1:0][S_W:0]   diff;
    logic [NLANE-1:0]          ge;
    logic [NLANE-1:0][S_W-1:0] rem_nxt;
    logic [NLANE-1:0][Q_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign cur_vld  = fi.vld;
      assign cur_meta = fi.meta;
      assign cur_s    = fi.s;
      assign cur_rem  = fi.n;
      assign cur_quo  = '0;
    end else begin : g_next
      assign cur_vld  = vld_r[k-1];
      assign cur_meta = meta_r[k-1];
      assign cur_s    = s_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_quo  = quo_r[k-1];
    end

    // first step takes the integer bit, later ones shift the remainder in
    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        trial[l]   = (k == 0) ? {1'b0, cur_rem[l]} : {cur_rem[l], 1'b0};
        diff[l]    = trial[l] - {1'b0, cur_s};
        ge[l]      = trial[l] >= {1'b0, cur_s};
        rem_nxt[l] = ge[l] ? diff[l][S_W-1:0] : trial[l][S_W-1:0];
        quo_nxt[l] = {cur_quo[l][Q_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= cur_vld;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[k] <= cur_meta;
        s_r[k]    <= cur_s;
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
      end
    end
  end

  assign qo.vld  = vld_r[DIV_STEPS-1];
  assign qo.meta = meta_r[DIV_STEPS-1];
  assign qo.q    = quo_r[DIV_STEPS-1];

endmodule

`default_nettype wire

/* design/alsd_back.sv */
// alsd_back: five-stage back end: round axis products, scale by K, forces, saturation
// depends on alsd_pkg; fed by alsd_div
`default_nettype none

module alsd_back
  import alsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  quo_t              qi,
  input  logic [DATA_W-1:0] stiff,
  output logic              out_vld,
  output out_item_t         out_data
);

  // stage 1: rounded axis products, special axes override, entry signs
  logic [NLANE-1:0][P_W-1:0] p_nxt;
  logic [NLANE-1:0]          ps_nxt;
  logic [Q_W:0]              qp;
  logic                      v1_r;
  logic [NLANE-1:0][P_W-1:0] p1_r;
  logic [NLANE-1:0]          ps1_r;
  meta_t                     meta1_r;

  always_comb begin
    ps_nxt = '0;
    for (int l = 0; l < NLANE; l++) begin
      qp = {1'b0, qi.q[l]} + 1'b1;
      case (qi.meta.acase)
        AXIS_GENERAL:    p_nxt[l] = qp[P_W:1];
        AXIS_SNAP_Z:     p_nxt[l] = (l == L_ZZ) ? AXIS_ONE : '0;
        AXIS_COINCIDENT: p_nxt[l] = (l == L_XX) ? AXIS_ONE : '0;
        default:         p_nxt[l] = '0;
      endcase
    end
    if (qi.meta.acase == AXIS_GENERAL) begin
      ps_nxt[L_XY] = qi.meta.dn[0] ^ qi.meta.dn[1];
      ps_nxt[L_XZ] = qi.meta.dn[0] ^ qi.meta.dn[2];
      ps_nxt[L_YZ] = qi.meta.dn[1] ^ qi.meta.dn[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= qi.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p_nxt;
      ps1_r   <= ps_nxt;
      meta1_r <= qi.meta;
    end
  end

  // stage 2: K times axis product
  logic                       v2_r;
  logic [NLANE-1:0][KP_W-1:0] kp2_r;
  logic [NLANE-1:0]           ps2_r;
  meta_t                      meta2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) kp2_r[l] <= stiff * p1_r[l];
      ps2_r   <= ps1_r;
      meta2_r <= meta1_r;
    end
  end

  // stage 3: round half up, signed block entries with saturation
  logic [NLANE-1:0][KP_W-1:0]   kr;
  logic [NLANE-1:0][DATA_W-1:0] m_nxt;
  logic [NLANE-1:0][DATA_W-1:0] ko_nxt;
  logic [NLANE-1:0]             ks_nxt;
  logic                         v3_r;
  logic [NLANE-1:0][DATA_W-1:0] m3_r;
  logic [NLANE-1:0][DATA_W-1:0] ko3_r;
  logic [NLANE-1:0]             ks3_r;
  logic [NLANE-1:0]             ps3_r;
  meta_t                        meta3_r;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      kr[l]    = kp2_r[l] + (KP_W'(1) << (AXIS_FRAC - 1));
      m_nxt[l] = kr[l][AXIS_FRAC +: DATA_W];
      if (ps2_r[l]) begin
        ks_nxt[l] = m_nxt[l] > NEG_MAX;
        ko_nxt[l] = ks_nxt[l] ? NEG_MAX : (~m_nxt[l] + 1'b1);
      end else begin
        ks_nxt[l] = m_nxt[l][DATA_W-1];
        ko_nxt[l] = ks_nxt[l] ? POS_MAX : m_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r    <= m_nxt;
      ko3_r   <= ko_nxt;
      ks3_r   <= ks_nxt;
      ps3_r   <= ps2_r;
      meta3_r <= meta2_r;
    end
  end

  // stage 4: force term products with their signs
  logic                         v4_r;
  logic [2:0][2:0][FP_W-1:0]    fp4_r;
  logic [2:0][2:0]              fn4_r;
  logic [NLANE-1:0][DATA_W-1:0] ko4_r;
  logic [NLANE-1:0]             ks4_r;
  axis_case_t                   acase4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          fp4_r[i][j] <= m3_r[LANE_OF[i][j]] * meta3_r.um[j];
          fn4_r[i][j] <= ~(ps3_r[LANE_OF[i][j]] ^ meta3_r.un[j]);
        end
      end
      ko4_r    <= ko3_r;
      ks4_r    <= ks3_r;
      acase4_r <= meta3_r.acase;
    end
  end

  // stage 5: sum, round half up, saturate into the output register
  logic [2:0][2:0][ACC_W-1:0] term;
  logic [2:0][ACC_W-1:0]      acc;
  logic [2:0]                 fit;
  logic [2:0][DATA_W-1:0]     fo_nxt;
  logic                       v5_r;
  out_item_t                  out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        term[i][j] = fn4_r[i][j] ? (~ACC_W'(fp4_r[i][j]) + 1'b1) : ACC_W'(fp4_r[i][j]);
      end
      acc[i] = term[i][0] + term[i][1] + term[i][2] + (ACC_W'(1) << (FRAC_BITS - 1));
      fit[i] = (acc[i][ACC_W-1:FRAC_BITS+DATA_W-1] == '0)
            || (acc[i][ACC_W-1:FRAC_BITS+DATA_W-1] == '1);
      if (fit[i]) fo_nxt[i] = acc[i][FRAC_BITS +: DATA_W];
      else fo_nxt[i] = acc[i][ACC_W-1] ? NEG_MAX : POS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.k_xx      <= ko4_r[L_XX];
      out_r.k_yy      <= ko4_r[L_YY];
      out_r.k_zz      <= ko4_r[L_ZZ];
      out_r.k_xy      <= ko4_r[L_XY];
      out_r.k_xz      <= ko4_r[L_XZ];
      out_r.k_yz      <= ko4_r[L_YZ];
      out_r.force_x   <= fo_nxt[0];
      out_r.force_y   <= fo_nxt[1];
      out_r.force_z   <= fo_nxt[2];
      out_r.axis_case <= acase4_r;
      out_r.saturated <= (|ks4_r) | ~(&fit);
    end
  end

  assign out_vld  = v5_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

/* design/alsd_checker.sv */
// alsd_sva: port-level assertions for the axial link stiffness top level
// depends on alsd_pkg; bound to axial_link_stiffness_3d_top below
`default_nettype none

module alsd_sva
  import alsd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a waiting result item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // input side never stalls while no result item is valid
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // coincident nodes leave only the xx entry
  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_case == AXIS_COINCIDENT |->
      out_data.k_yy == '0 && out_data.k_zz == '0 && out_data.k_xy == '0 &&
      out_data.k_xz == '0 && out_data.k_yz == '0)
    else $error("coincident item has entries off xx");

  // snapped axis leaves only the zz entry
  a_snap_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_case == AXIS_SNAP_Z |->
      out_data.k_xx == '0 && out_data.k_yy == '0 && out_data.k_xy == '0 &&
      out_data.k_xz == '0 && out_data.k_yz == '0)
    else $error("snapped item has entries off zz");

  // diagonal entries never go negative
  a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.k_xx[DATA_W-1] && !out_data.k_yy[DATA_W-1] &&
      !out_data.k_zz[DATA_W-1])
    else $error("negative diagonal entry");

endmodule

bind axial_link_stiffness_3d_top alsd_sva u_alsd_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

`default_nettype wire
